// File: rtl/mcg_pkg.sv
`timescale 1ns / 1ps

package mcg_pkg;

  localparam int CFG_BITS        = 10;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int KEY_FIELD_BITS  = 16;
  localparam int DUTY_FIELD_BITS = 16;
  localparam int SERVO_BITS      = 8;
  localparam int MODE_BITS       = 2;

  localparam logic [CFG_BITS-1:0] WAIT_TICKS_RESET    = 10'd250;
  localparam logic [CFG_BITS-1:0] HOLDOFF_TICKS_RESET = 10'd50;
  localparam logic [CFG_BITS-1:0] TIMEOUT_TICKS_RESET = 10'd25;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAIT_TICKS    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLDOFF_TICKS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_WAITING = 2'd1,
    MODE_HOLDOFF = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] wait_ticks;
    logic [CFG_BITS-1:0] holdoff_ticks;
    logic [CFG_BITS-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic bump;
    logic timed_out;
  } tick_flags_t;

endpackage

// File: rtl/mcg_cfg_regs.sv
`timescale 1ns / 1ps

module mcg_cfg_regs
  import mcg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_TICKS:    cfg_nxt.wait_ticks    = cfg_wdata;
        CFG_HOLDOFF_TICKS: cfg_nxt.holdoff_ticks = cfg_wdata;
        CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_ticks    <= WAIT_TICKS_RESET;
      cfg_r.holdoff_ticks <= HOLDOFF_TICKS_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/mcg_tick_logic.sv
`timescale 1ns / 1ps

module mcg_tick_logic
  import mcg_pkg::*;
#(
  parameter int KEY_BITS   = 16,
  parameter int DUTY_BITS  = 16,
  parameter int COUNT_BITS = 10
) (
  input  cfg_t                       cfg,
  input  logic                       bumper_hit,
  input  logic                       cmd_valid,
  input  logic                       cmd_set_key,
  input  logic [KEY_FIELD_BITS-1:0]  cmd_key,
  input  logic [DUTY_FIELD_BITS-1:0] cmd_left_duty,
  input  logic [DUTY_FIELD_BITS-1:0] cmd_right_duty,
  input  logic                       cmd_left_dir,
  input  logic                       cmd_right_dir,
  input  logic [SERVO_BITS-1:0]      cmd_servo,
  input  mode_t                      mode_cur,
  input  logic [COUNT_BITS-1:0]      wait_count_cur,
  input  logic [COUNT_BITS-1:0]      holdoff_count_cur,
  input  logic [COUNT_BITS-1:0]      watchdog_cur,
  input  logic [KEY_BITS-1:0]        session_key_cur,
  input  logic [DUTY_BITS-1:0]       left_duty_cur,
  input  logic [DUTY_BITS-1:0]       right_duty_cur,
  input  logic                       left_dir_cur,
  input  logic                       right_dir_cur,
  input  logic [SERVO_BITS-1:0]      servo_cur,
  output mode_t                      mode_new,
  output logic [COUNT_BITS-1:0]      wait_count_new,
  output logic [COUNT_BITS-1:0]      holdoff_count_new,
  output logic [COUNT_BITS-1:0]      watchdog_new,
  output logic [KEY_BITS-1:0]        session_key_new,
  output logic [DUTY_BITS-1:0]       left_duty_new,
  output logic [DUTY_BITS-1:0]       right_duty_new,
  output logic                       left_dir_new,
  output logic                       right_dir_new,
  output logic [SERVO_BITS-1:0]      servo_new,
  output tick_flags_t                flags
);

  localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  mode_t                 mode_seq;
  logic [COUNT_BITS-1:0] wait_inc;
  logic [COUNT_BITS-1:0] holdoff_inc;
  logic [COUNT_BITS-1:0] watchdog_inc;
  logic                  bump;
  logic [KEY_BITS-1:0]   key_in;
  logic                  key_match;
  logic                  cmd_take;
  logic                  watchdog_clear;
  logic                  timed_out;

  assign wait_inc    = wait_count_cur + 1'b1;
  assign holdoff_inc = holdoff_count_cur + 1'b1;

  // Mode sequencer followed by the bump check.
  always_comb begin
    mode_seq          = mode_cur;
    wait_count_new    = wait_count_cur;
    holdoff_count_new = holdoff_count_cur;
    case (mode_cur)
      MODE_WAITING: begin
        if (CMP_BITS'(wait_inc) >= CMP_BITS'(cfg.wait_ticks)) begin
          wait_count_new = '0;
          mode_seq       = MODE_HOLDOFF;
        end else begin
          wait_count_new = wait_inc;
        end
      end
      MODE_HOLDOFF: begin
        if (CMP_BITS'(holdoff_inc) >= CMP_BITS'(cfg.holdoff_ticks)) begin
          holdoff_count_new = '0;
          mode_seq          = MODE_NORMAL;
        end else begin
          holdoff_count_new = holdoff_inc;
        end
      end
      default: mode_seq = mode_cur;
    endcase
    bump     = (mode_seq != MODE_HOLDOFF) && bumper_hit;
    mode_new = bump ? MODE_WAITING : mode_seq;
  end

  assign watchdog_inc   = (watchdog_cur == COUNT_MAX) ? watchdog_cur : watchdog_cur + 1'b1;
  assign key_in         = KEY_BITS'(cmd_key);
  assign key_match      = (key_in == session_key_cur);
  assign cmd_take       = cmd_valid && !cmd_set_key && key_match;
  assign watchdog_clear = cmd_valid && (cmd_set_key || key_match);
  assign watchdog_new   = watchdog_clear ? '0 : watchdog_inc;
  assign session_key_new = (cmd_valid && cmd_set_key) ? key_in : session_key_cur;
  assign timed_out      = CMP_BITS'(watchdog_new) >= CMP_BITS'(cfg.timeout_ticks);

  // Motor and servo outputs.
  always_comb begin
    left_duty_new  = left_duty_cur;
    right_duty_new = right_duty_cur;
    left_dir_new   = left_dir_cur;
    right_dir_new  = right_dir_cur;
    servo_new      = servo_cur;
    if (bump) begin
      left_duty_new  = '0;
      right_duty_new = '0;
      left_dir_new   = 1'b0;
      right_dir_new  = 1'b0;
    end
    if (cmd_take) begin
      servo_new = cmd_servo;
      if (mode_new != MODE_WAITING) begin
        left_duty_new  = DUTY_BITS'(cmd_left_duty);
        right_duty_new = DUTY_BITS'(cmd_right_duty);
        left_dir_new   = cmd_left_dir;
        right_dir_new  = cmd_right_dir;
      end
    end
    if (timed_out) begin
      left_duty_new  = '0;
      right_duty_new = '0;
      left_dir_new   = 1'b0;
      right_dir_new  = 1'b0;
    end
    flags.bump      = bump;
    flags.timed_out = timed_out;
  end

endmodule

// File: rtl/motor_command_gate_with_bump_lockout.sv
`timescale 1ns / 1ps

// Motor command gate with bump lockout.
// Each input transfer is one control tick: the bumper level plus an optional
// radio command. Each tick produces exactly one output transfer carrying the
// motor duties and directions, servo position, mode and the bump and
// link-timeout flags after that tick.
// Both channels use valid and stall; a transfer happens on a rising edge
// with valid high and stall low.
// The tick is evaluated by combinational logic from the held state and
// written into the state registers and the output register at the edge
// where the input transfer happens; the result shows in the next cycle.
// One tick is accepted every cycle while the output side is not stalled.
// When the receiver stalls with a result pending, in_stall is raised in the
// same cycle and the result holds until taken.
// The user must write configuration through cfg_we, cfg_index and cfg_wdata
// only while the block is idle; the block does not enforce this. Writes to
// an unused index are ignored. Synchronous active-low reset returns the mode
// to normal, clears counters, session key, duties, directions and servo, loads
// the tick registers with 250, 50 and 25, and empties the output register.
module motor_command_gate_with_bump_lockout
  import mcg_pkg::*;
#(
  parameter int KEY_BITS   = 16,
  parameter int DUTY_BITS  = 16,
  parameter int COUNT_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]        cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_bumper_hit,
  input  logic                       in_cmd_valid,
  input  logic                       in_cmd_set_key,
  input  logic [KEY_FIELD_BITS-1:0]  in_cmd_key,
  input  logic [DUTY_FIELD_BITS-1:0] in_cmd_left_duty,
  input  logic [DUTY_FIELD_BITS-1:0] in_cmd_right_duty,
  input  logic                       in_cmd_left_dir,
  input  logic                       in_cmd_right_dir,
  input  logic [SERVO_BITS-1:0]      in_cmd_servo,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DUTY_FIELD_BITS-1:0] out_left_duty,
  output logic [DUTY_FIELD_BITS-1:0] out_right_duty,
  output logic                       out_left_dir,
  output logic                       out_right_dir,
  output logic [SERVO_BITS-1:0]      out_servo_angle,
  output logic [MODE_BITS-1:0]       out_mode,
  output logic                       out_bump_report,
  output logic                       out_link_timed_out
);

  cfg_t cfg;

  mode_t                 mode_r;
  logic [COUNT_BITS-1:0] wait_count_r;
  logic [COUNT_BITS-1:0] holdoff_count_r;
  logic [COUNT_BITS-1:0] watchdog_r;
  logic [KEY_BITS-1:0]   session_key_r;
  logic [DUTY_BITS-1:0]  left_duty_r;
  logic [DUTY_BITS-1:0]  right_duty_r;
  logic                  left_dir_r;
  logic                  right_dir_r;
  logic [SERVO_BITS-1:0] servo_r;

  mode_t                 mode_nxt;
  logic [COUNT_BITS-1:0] wait_count_nxt;
  logic [COUNT_BITS-1:0] holdoff_count_nxt;
  logic [COUNT_BITS-1:0] watchdog_nxt;
  logic [KEY_BITS-1:0]   session_key_nxt;
  logic [DUTY_BITS-1:0]  left_duty_nxt;
  logic [DUTY_BITS-1:0]  right_duty_nxt;
  logic                  left_dir_nxt;
  logic                  right_dir_nxt;
  logic [SERVO_BITS-1:0] servo_nxt;
  tick_flags_t           flags_nxt;

  logic        out_valid_r;
  tick_flags_t out_flags_r;
  logic        in_xfer;
  logic        out_xfer;

  mcg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mcg_tick_logic #(
    .KEY_BITS   (KEY_BITS),
    .DUTY_BITS  (DUTY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_tick_logic (
    .cfg               (cfg),
    .bumper_hit        (in_bumper_hit),
    .cmd_valid         (in_cmd_valid),
    .cmd_set_key       (in_cmd_set_key),
    .cmd_key           (in_cmd_key),
    .cmd_left_duty     (in_cmd_left_duty),
    .cmd_right_duty    (in_cmd_right_duty),
    .cmd_left_dir      (in_cmd_left_dir),
    .cmd_right_dir     (in_cmd_right_dir),
    .cmd_servo         (in_cmd_servo),
    .mode_cur          (mode_r),
    .wait_count_cur    (wait_count_r),
    .holdoff_count_cur (holdoff_count_r),
    .watchdog_cur      (watchdog_r),
    .session_key_cur   (session_key_r),
    .left_duty_cur     (left_duty_r),
    .right_duty_cur    (right_duty_r),
    .left_dir_cur      (left_dir_r),
    .right_dir_cur     (right_dir_r),
    .servo_cur         (servo_r),
    .mode_new          (mode_nxt),
    .wait_count_new    (wait_count_nxt),
    .holdoff_count_new (holdoff_count_nxt),
    .watchdog_new      (watchdog_nxt),
    .session_key_new   (session_key_nxt),
    .left_duty_new     (left_duty_nxt),
    .right_duty_new    (right_duty_nxt),
    .left_dir_new      (left_dir_nxt),
    .right_dir_new     (right_dir_nxt),
    .servo_new         (servo_nxt),
    .flags             (flags_nxt)
  );

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_NORMAL;
      wait_count_r    <= '0;
      holdoff_count_r <= '0;
      watchdog_r      <= '0;
      session_key_r   <= '0;
      left_duty_r     <= '0;
      right_duty_r    <= '0;
      left_dir_r      <= 1'b0;
      right_dir_r     <= 1'b0;
      servo_r         <= '0;
      out_valid_r     <= 1'b0;
      out_flags_r     <= '0;
    end else begin
      if (in_xfer) begin
        mode_r          <= mode_nxt;
        wait_count_r    <= wait_count_nxt;
        holdoff_count_r <= holdoff_count_nxt;
        watchdog_r      <= watchdog_nxt;
        session_key_r   <= session_key_nxt;
        left_duty_r     <= left_duty_nxt;
        right_duty_r    <= right_duty_nxt;
        left_dir_r      <= left_dir_nxt;
        right_dir_r     <= right_dir_nxt;
        servo_r         <= servo_nxt;
        out_flags_r     <= flags_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The state registers double as the output register: they change only on
  // an input transfer, which cannot happen while a result is stalled.
  assign out_valid          = out_valid_r;
  assign out_left_duty      = DUTY_FIELD_BITS'(left_duty_r);
  assign out_right_duty     = DUTY_FIELD_BITS'(right_duty_r);
  assign out_left_dir       = left_dir_r;
  assign out_right_dir      = right_dir_r;
  assign out_servo_angle    = servo_r;
  assign out_mode           = mode_r;
  assign out_bump_report    = out_flags_r.bump;
  assign out_link_timed_out = out_flags_r.timed_out;

  a_bump_enters_waiting : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flags_r.bump) |-> (mode_r == MODE_WAITING))
    else $error("bump reported outside waiting mode");

  a_timeout_stops_motors : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flags_r.timed_out) |->
      (left_duty_r == '0 && right_duty_r == '0 && !left_dir_r && !right_dir_r))
    else $error("timeout left a motor running");

  a_wait_count_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (wait_count_r != '0) |-> (mode_r == MODE_WAITING))
    else $error("wait count nonzero outside waiting mode");

  a_holdoff_count_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (holdoff_count_r != '0) |-> (mode_r == MODE_HOLDOFF))
    else $error("holdoff count nonzero outside holdoff mode");

  a_normal_no_holdoff : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && mode_r == MODE_NORMAL) |=> (mode_r != MODE_HOLDOFF))
    else $error("normal mode went straight to holdoff");

endmodule
